// ===== sv/ssc_pkg.sv =====
// stanley steering controller package: register indexes, sequencer states,
// cordic arctangent table. no dependencies.
package ssc_pkg;

    typedef enum logic [2:0]
    {
        REG_GAIN_FWD   = 3'd0,
        REG_SOFT_FWD   = 3'd1,
        REG_GAIN_REV   = 3'd2,
        REG_SOFT_REV   = 3'd3,
        REG_YAW_DAMP   = 3'd4,
        REG_STEER_DAMP = 3'd5,
        REG_MAX_STEER  = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_MUL_NUM,
        ST_SETUP,
        ST_CORDIC,
        ST_ROUND,
        ST_MUL_YAW,
        ST_MUL_STEER,
        ST_SUM,
        ST_OUT
    } state_t;

    localparam int unsigned AtanMax = 24;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/stanley_steering_controller_top.sv =====
// stanley steering controller top level: stream in/out, apb registers,
// one shared multiplier and a cordic sequencer. uses ssc_pkg.
//
// channel | dir | fields
// s_axis  | in  | tdata: measured_steer, speed, front_yaw, rear_yaw, path_heading,
//         |     |        cross_err, err_valid; tuser: skip
// m_axis  | out | tdata: steer_request
// apb     | in  | seven registers at 4*i
// a forward item goes PREP, MUL_NUM, SETUP, CORDIC (steps rounds), ROUND, SUM, OUT;
// a reverse item adds MUL_YAW and MUL_STEER after ROUND; steps is CORDIC_STEPS limited
// to 24. a skipped item stays in IDLE; an invalid one goes from PREP back to IDLE.
// s_axis_tready is low while an item is at work; a finished result waits in
// ST_OUT while m_axis still holds an earlier one.
// reset is asynchronous, active low, and clears config, history and state, not datapath.
module stanley_steering_controller_top
    import ssc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // measured_steer[15:0] speed[31:16] front_yaw[47:32] rear_yaw[63:48]
    // path_heading[79:64] cross_err[103:80] err_valid[104], zero to 111
    input  logic [111:0] s_axis_tdata,
    // skip
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // steer_request[15:0]
    output logic [15:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int Steps = (CORDIC_STEPS > int'(AtanMax)) ? int'(AtanMax) : CORDIC_STEPS;

    logic [15:0] gain_fwd_reg, gain_rev_reg, yaw_damp_reg, steer_damp_reg;
    logic [14:0] soft_fwd_reg, soft_rev_reg, max_steer_reg;
    logic signed [15:0] last_steer_reg, last_rear_yaw_reg, last_rear_path_reg;

    state_t state_reg, state_next;

    logic signed [15:0] steer_reg, speed_reg, fyaw_reg, ryaw_reg, path_reg;
    logic signed [23:0] xte_reg;
    logic               valid_reg;
    logic               rev_reg;

    logic signed [41:0] num_reg;
    logic signed [17:0] den_reg;
    logic signed [44:0] x_reg, y_reg;
    logic signed [35:0] z_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    logic signed [17:0] term_reg;
    logic signed [19:0] acc_reg;
    logic signed [15:0] res_reg;
    logic               out_valid_reg;

    wire wr_en = psel && penable && pwrite;
    wire [2:0] widx = paddr[4:2];
    wire out_go = !out_valid_reg || m_axis_tready;

    assign pready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = res_reg;

    always_comb
    begin
        prdata = 32'd0;
        case (reg_idx_t'(widx))
            REG_GAIN_FWD:   prdata = {16'd0, gain_fwd_reg};
            REG_SOFT_FWD:   prdata = {17'd0, soft_fwd_reg};
            REG_GAIN_REV:   prdata = {16'd0, gain_rev_reg};
            REG_SOFT_REV:   prdata = {17'd0, soft_rev_reg};
            REG_YAW_DAMP:   prdata = {16'd0, yaw_damp_reg};
            REG_STEER_DAMP: prdata = {16'd0, steer_damp_reg};
            REG_MAX_STEER:  prdata = {17'd0, max_steer_reg};
            default:        prdata = 32'd0;
        endcase
        if (paddr[1:0] != 2'd0)
        begin
            prdata = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_fwd_reg   <= 16'd256;
            soft_fwd_reg   <= 15'd1000;
            gain_rev_reg   <= 16'd256;
            soft_rev_reg   <= 15'd1000;
            yaw_damp_reg   <= 16'd0;
            steer_damp_reg <= 16'd0;
            max_steer_reg  <= 15'd7282;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(widx))
                REG_GAIN_FWD:   gain_fwd_reg   <= pwdata[15:0];
                REG_SOFT_FWD:   soft_fwd_reg   <= pwdata[14:0];
                REG_GAIN_REV:   gain_rev_reg   <= pwdata[15:0];
                REG_SOFT_REV:   soft_rev_reg   <= pwdata[14:0];
                REG_YAW_DAMP:   yaw_damp_reg   <= pwdata[15:0];
                REG_STEER_DAMP: steer_damp_reg <= pwdata[15:0];
                REG_MAX_STEER:  max_steer_reg  <= pwdata[14:0];
                default:        ;
            endcase
        end
    end

    // shared multiplier: 17 bit signed by 25 bit signed
    logic signed [24:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [41:0] mul_p;
    logic signed [15:0] d_yaw, d_steer, d_path;

    assign d_yaw   = last_rear_yaw_reg - ryaw_reg;
    assign d_steer = last_steer_reg - steer_reg;
    assign d_path  = last_rear_path_reg - path_reg;

    always_comb
    begin
        mul_a = 25'sd0;
        mul_b = 17'sd0;
        case (state_reg)
            ST_MUL_NUM:
            begin
                mul_a = -{xte_reg[23], xte_reg};
                mul_b = {1'b0, rev_reg ? gain_rev_reg : gain_fwd_reg};
            end
            ST_MUL_YAW:
            begin
                mul_a = 25'(d_yaw);
                mul_b = {1'b0, yaw_damp_reg};
            end
            ST_MUL_STEER:
            begin
                mul_a = 25'(d_steer);
                mul_b = {1'b0, steer_damp_reg};
            end
            default:
            begin
                mul_a = 25'sd0;
                mul_b = 17'sd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    wire signed [41:0] damp_w = (mul_p + 42'sd2048) >>> 12;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready && !s_axis_tuser)
                    state_next = ST_PREP;
            ST_PREP:      state_next = valid_reg ? ST_MUL_NUM : ST_IDLE;
            ST_MUL_NUM:   state_next = ST_SETUP;
            ST_SETUP:     state_next = ST_CORDIC;
            ST_CORDIC:
                if (cnt_reg == 5'(Steps - 1))
                    state_next = ST_ROUND;
            ST_ROUND:     state_next = rev_reg ? ST_MUL_YAW : ST_SUM;
            ST_MUL_YAW:   state_next = ST_MUL_STEER;
            ST_MUL_STEER: state_next = ST_SUM;
            ST_SUM:       state_next = ST_OUT;
            ST_OUT:       state_next = out_go ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    logic signed [44:0] dx, dy;
    logic signed [35:0] zr;
    logic signed [19:0] rr;
    logic signed [19:0] wsum;
    logic signed [16:0] resn, lim;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign zr = (z_reg + 36'sd32768) >>> 16;
    assign wsum = acc_reg;
    assign lim = {2'b00, max_steer_reg};

    always_comb
    begin
        rr = zr[19:0];
        if (zr < 0)
            rr = 20'sd0;
        else if (zr > 36'sd16384)
            rr = 20'sd16384;
        resn = rev_reg ? -17'(signed'(wsum[15:0])) : 17'(signed'(wsum[15:0]));
        if (resn > lim)
            resn = lim;
        if (resn < -lim)
            resn = -lim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            last_steer_reg     <= 16'sd0;
            last_rear_yaw_reg  <= 16'sd0;
            last_rear_path_reg <= 16'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_PREP:
                    if (!valid_reg)
                    begin
                        last_steer_reg    <= steer_reg;
                        last_rear_yaw_reg <= ryaw_reg;
                    end
                ST_OUT:
                    if (out_go)
                    begin
                        out_valid_reg     <= 1'b1;
                        last_steer_reg    <= steer_reg;
                        last_rear_yaw_reg <= ryaw_reg;
                        if (rev_reg)
                            last_rear_path_reg <= path_reg;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    steer_reg <= s_axis_tdata[15:0];
                    speed_reg <= s_axis_tdata[31:16];
                    fyaw_reg  <= s_axis_tdata[47:32];
                    ryaw_reg  <= s_axis_tdata[63:48];
                    path_reg  <= s_axis_tdata[79:64];
                    xte_reg   <= s_axis_tdata[103:80];
                    valid_reg <= s_axis_tdata[104];
                end
            ST_PREP:
            begin
                rev_reg <= speed_reg[15];
                den_reg <= speed_reg[15]
                    ? 18'(speed_reg) - 18'(soft_rev_reg)
                    : 18'(speed_reg) + 18'(soft_fwd_reg);
            end
            ST_MUL_NUM:
                num_reg <= mul_p;
            ST_SETUP:
            begin
                neg_reg <= (num_reg < 0) ^ (den_reg < 0);
                y_reg   <= (num_reg < 0) ? -45'(num_reg) : 45'(num_reg);
                x_reg   <= (den_reg < 0) ? -(45'(den_reg) <<< 8) : (45'(den_reg) <<< 8);
                z_reg   <= 36'sd0;
                cnt_reg <= 5'd0;
            end
            ST_CORDIC:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + 36'(atan_lut(cnt_reg));
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - 36'(atan_lut(cnt_reg));
                end
            end
            ST_ROUND:
            begin
                if (num_reg == 0)
                    term_reg <= 18'sd0;
                else if (den_reg == 0)
                    term_reg <= (num_reg > 0) ? 18'sd16384 : -18'sd16384;
                else
                    term_reg <= neg_reg ? -18'(rr) : 18'(rr);
                acc_reg <= 20'(path_reg) - (rev_reg ? 20'(ryaw_reg) : 20'(fyaw_reg));
            end
            ST_MUL_YAW:
                acc_reg <= acc_reg + 20'(damp_w) - 20'(d_path);
            ST_MUL_STEER:
                acc_reg <= acc_reg + 20'(damp_w);
            ST_SUM:
                acc_reg <= acc_reg + 20'(term_reg);
            ST_OUT:
                if (out_go)
                    res_reg <= resn[15:0];
            default: ;
        endcase
    end

endmodule
